### sv/triangle_voxel_overlap_test_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle / voxel overlap test
// Shared property shapes, clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_VOXEL_OVERLAP_TEST_TOP_MACROS_SVH
`define TRIANGLE_VOXEL_OVERLAP_TEST_TOP_MACROS_SVH

// same-cycle implication
`define TVO_ASSERT_HOLD(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TVO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tvo_pkg.sv
// ----------------------------------------------------------------------------
// tvo_pkg
// Shared constants, codes and types of the triangle / voxel overlap test.
// ----------------------------------------------------------------------------
package tvo_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int GRID_MAX       = 128;
    localparam int CS_W           = 31;
    localparam int IDX_W          = 7;
    localparam int MAT_W          = 8;
    localparam int CELL_MIN       = 7;
    localparam int AXIS_SQ_MIN    = 171;
    localparam int LIMB_W         = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CELL_SIZE_RST  = 65536;
    localparam int MATERIAL_RST   = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MATERIAL  = 3'd4;

    // separating axis class
    typedef enum logic [1:0] {
        SEP_NONE   = 2'd0,
        SEP_BOX    = 2'd1,
        SEP_NORMAL = 2'd2,
        SEP_CROSS  = 2'd3
    } t_sep;

    typedef struct packed {
        logic             overlap;
        logic [MAT_W-1:0] value;
        t_sep             sep;
    } t_res;

endpackage

### sv/tvo_in_if.sv
// ----------------------------------------------------------------------------
// tvo_in_if
// Triangle and cell index channel, valid/ready.
// ----------------------------------------------------------------------------
interface tvo_in_if #(
    parameter int COORD_BITS = tvo_pkg::COORD_BITS_DEF
) ();
    import tvo_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x, a_y, a_z;
    logic signed [COORD_BITS-1:0] b_x, b_y, b_z;
    logic signed [COORD_BITS-1:0] c_x, c_y, c_z;
    logic [IDX_W-1:0]             cell_x, cell_y, cell_z;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
               cell_x, cell_y, cell_z,
        input  ready
    );

    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
               cell_x, cell_y, cell_z,
        output ready
    );
endinterface

### sv/tvo_out_if.sv
// ----------------------------------------------------------------------------
// tvo_out_if
// Overlap result channel, valid/ready.
// ----------------------------------------------------------------------------
interface tvo_out_if ();
    import tvo_pkg::*;

    logic             valid;
    logic             ready;
    logic             overlap;
    logic [MAT_W-1:0] voxel_value;
    logic [1:0]       separated_by;

    modport source (
        output valid, overlap, voxel_value, separated_by,
        input  ready
    );

    modport sink (
        input  valid, overlap, voxel_value, separated_by,
        output ready
    );
endinterface

### sv/tvo_mul.sv
// ----------------------------------------------------------------------------
// tvo_mul
// Pipelined signed multiplier built from 32x32 limb products.
// ----------------------------------------------------------------------------
module tvo_mul #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);
    import tvo_pkg::*;

    localparam int LA = (WA + LIMB_W - 1) / LIMB_W;
    localparam int LB = (WB + LIMB_W - 1) / LIMB_W;
    localparam int WP = WA + WB;
    localparam int WS = (LA + LB) * LIMB_W;

    logic [WA-1:0]          w_ma;
    logic [WB-1:0]          w_mb;
    logic [LA*LIMB_W-1:0]   r_ma;
    logic [LB*LIMB_W-1:0]   r_mb;
    logic                   r_sg1, r_sg2, r_sg3;
    logic [2*LIMB_W-1:0]    r_pp [LA][LB];
    logic [WS-1:0]          n_sum;
    logic [WP-1:0]          r_sum;

    // magnitudes of both operands
    assign w_ma = i_a[WA-1] ? -i_a : i_a;
    assign w_mb = i_b[WB-1] ? -i_b : i_b;

    // add the shifted limb products
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < LA; i++) begin
            for (int j = 0; j < LB; j++) begin
                n_sum = n_sum + (WS'(r_pp[i][j]) << (LIMB_W * (i + j)));
            end
        end
    end

    // magnitude, limb products, sum, sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma  <= (LA*LIMB_W)'(w_ma);
            r_mb  <= (LB*LIMB_W)'(w_mb);
            r_sg1 <= i_a[WA-1] ^ i_b[WB-1];
            for (int i = 0; i < LA; i++) begin
                for (int j = 0; j < LB; j++) begin
                    r_pp[i][j] <= (2*LIMB_W)'(r_ma[i*LIMB_W +: LIMB_W])
                                * (2*LIMB_W)'(r_mb[j*LIMB_W +: LIMB_W]);
                end
            end
            r_sg2 <= r_sg1;
            r_sum <= n_sum[WP-1:0];
            r_sg3 <= r_sg2;
            o_p   <= r_sg3 ? -signed'(r_sum) : signed'(r_sum);
        end
    end

endmodule

### sv/triangle_voxel_overlap_test_top.sv
// An accepted word passes stage registers s0 to s16, then the output register.
// Throughput: one word per cycle while the skid word is empty. The multiplier
// bank (64 limb-split multipliers, 4 stages each, in two rounds) is fully
// pipelined. A stalled output is absorbed by one skid word before
// i_tri.ready drops. Reset (synchronous, active low) clears valid bits and
// loads the registers: origin 0, cell size 1.0, material 1.
// ----------------------------------------------------------------------------
// triangle_voxel_overlap_test_top
// Separating axis test of a triangle against one grid voxel, in exact
// doubled fixed-point integers: box axes, triangle normal, each edge crossed with each box axis.
// ----------------------------------------------------------------------------
`include "triangle_voxel_overlap_test_top_macros.svh"

module triangle_voxel_overlap_test_top #(
    parameter int COORD_BITS = tvo_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [tvo_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [((COORD_BITS > tvo_pkg::CS_W) ? COORD_BITS : tvo_pkg::CS_W)-1:0] i_cfg_data,
    tvo_in_if.sink                                 i_tri,
    tvo_out_if.source                              o_res
);
    import tvo_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int WOFF = 8 + CS_W;
    localparam int WC   = ((CW + 1 > WOFF + 1) ? CW + 1 : WOFF + 1) + 1;
    localparam int WV   = WC + 1;
    localparam int WE   = WV + 1;
    localparam int WN   = 2 * WE + 1;
    localparam int WP   = WE + WV + 1;
    localparam int WSQ  = 2 * WE + 1;
    localparam int WD   = WN + WV + 2;
    localparam int WNA  = WN + 2;
    localparam int WR   = WNA + CS_W + 1;
    localparam int WA3  = WE + 2;
    localparam int WR3  = WA3 + CS_W + 1;
    localparam int WX   = ((WP > WR3) ? WP : WR3) + 1;

    localparam int S_BOX  = 4;
    localparam int S_CRS  = 11;
    localparam int S_LAST = 16;

    function automatic int nx1(input int k);
        return (k == 2) ? 0 : k + 1;
    endfunction

    function automatic int nx2(input int k);
        return (k == 0) ? 2 : k - 1;
    endfunction

    function automatic logic signed [WA3-1:0] abs_e(input logic signed [WE-1:0] x);
        logic signed [WA3-1:0] t;
        t = WA3'(x);
        return x[WE-1] ? -t : t;
    endfunction

    function automatic logic signed [WNA-1:0] abs_n(input logic signed [WN-1:0] x);
        logic signed [WNA-1:0] t;
        t = WNA'(x);
        return x[WN-1] ? -t : t;
    endfunction

    // configuration registers
    logic signed [CW-1:0]  r_org [3];
    logic [CS_W-1:0]       r_cell_size;
    logic [MAT_W-1:0]      r_material;
    logic [CS_W-1:0]       w_cs;
    logic signed [CS_W:0]  w_cs32;
    logic signed [WV-1:0]  w_cs_v;

    // handshake and pipeline control
    logic                  w_en;
    logic                  w_acc;
    logic [S_LAST:0]       r_vld;
    logic [S_LAST:S_BOX]   r_box;
    logic [S_LAST:S_CRS]   r_crs;
    logic                  n_box;
    logic                  n_crs;

    // index wrap table
    logic [IDX_W-1:0]      w_wrap [1 << IDX_W];

    // pipeline payload
    logic signed [CW-1:0]    r_s0_vtx [3][3];
    logic [IDX_W-1:0]        r_s0_idx [3];
    logic signed [CW-1:0]    r_s1_vtx [3][3];
    logic signed [WOFF:0]    r_s1_off [3];
    logic signed [CW-1:0]    r_s2_vtx [3][3];
    logic signed [WC-1:0]    r_s2_ctr [3];
    logic signed [WV-1:0]    r_s3_v [3][3];
    logic signed [WE-1:0]    r_s4_e [3][3];
    logic signed [WV-1:0]    r_s4_v [3][3];
    logic signed [WE-1:0]    r_s5_e [3][3];
    logic signed [WV-1:0]    r_s5_v [3][3];
    logic signed [WA3-1:0]   r_s5_asum [3][3];
    logic signed [WV-1:0]    r_v0d [6:11][3];
    logic signed [WN-1:0]    r_s10_n [3];
    logic signed [WP-1:0]    r_s10_p [3][3][2];
    logic                    r_s10_sqok [3][3];
    logic signed [WR3-1:0]   r_s10_r3 [3][3];
    logic signed [WN-1:0]    r_s11_n [3];
    logic signed [WNA-1:0]   r_s11_nabs;
    logic signed [WD-1:0]    r_s16_d;
    logic signed [WR-1:0]    r_s16_r;

    // multiplier outputs
    logic signed [2*WE-1:0]  w_nm1 [3];
    logic signed [2*WE-1:0]  w_nm2 [3];
    logic signed [2*WE-1:0]  w_sq [3][3];
    logic signed [WE+WV-1:0] w_pm1 [3][3][2];
    logic signed [WE+WV-1:0] w_pm2 [3][3][2];
    logic signed [WR3-1:0]   w_r3 [3][3];
    logic signed [WN+WV-1:0] w_dm [3];
    logic signed [WR-1:0]    w_r;

    // output register and skid word
    logic                  r_out_v;
    logic                  r_skid_v;
    t_res                  r_out;
    t_res                  r_skid;
    t_res                  n_res;
    logic                  w_take;
    logic                  w_nrm;
    logic signed [WD-1:0]  w_rd;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]    <= '0;
            r_org[1]    <= '0;
            r_org[2]    <= '0;
            r_cell_size <= CS_W'(CELL_SIZE_RST);
            r_material  <= MAT_W'(MATERIAL_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ORIGIN_X:  r_org[0]    <= i_cfg_data[CW-1:0];
                REG_ORIGIN_Y:  r_org[1]    <= i_cfg_data[CW-1:0];
                REG_ORIGIN_Z:  r_org[2]    <= i_cfg_data[CW-1:0];
                REG_CELL_SIZE: r_cell_size <= i_cfg_data[CS_W-1:0];
                REG_MATERIAL:  r_material  <= i_cfg_data[MAT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp tiny cell sizes
    assign w_cs   = (r_cell_size < CS_W'(CELL_MIN)) ? CS_W'(CELL_MIN) : r_cell_size;
    assign w_cs32 = {1'b0, w_cs};
    assign w_cs_v = WV'(w_cs32);

    for (genvar g = 0; g < (1 << IDX_W); g++) begin : g_wrap
        assign w_wrap[g] = IDX_W'(g % GRID_MAX);
    end

    // ------------------------------------------------------------------
    // handshake: the pipeline moves while the skid word is empty
    // ------------------------------------------------------------------
    assign w_en        = !r_skid_v;
    assign i_tri.ready = !r_skid_v;
    assign w_acc       = i_tri.valid && i_tri.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[S_LAST-1:0], w_acc};
        end
    end

    // ------------------------------------------------------------------
    // box axes: all three vertices beyond the half extent
    // ------------------------------------------------------------------
    always_comb begin
        n_box = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if ((r_s3_v[0][k] > w_cs_v) && (r_s3_v[1][k] > w_cs_v)
                    && (r_s3_v[2][k] > w_cs_v)) begin
                n_box = 1'b1;
            end
            if ((r_s3_v[0][k] < -w_cs_v) && (r_s3_v[1][k] < -w_cs_v)
                    && (r_s3_v[2][k] < -w_cs_v)) begin
                n_box = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // edge cross axes: both distinct projections beyond the radius
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [WX-1:0] rr;
        logic signed [WX-1:0] p0;
        logic signed [WX-1:0] p1;
        n_crs = 1'b0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                rr = WX'(r_s10_r3[k][j]);
                p0 = WX'(r_s10_p[k][j][0]);
                p1 = WX'(r_s10_p[k][j][1]);
                if (r_s10_sqok[k][j]
                        && (((p0 > rr) && (p1 > rr)) || ((p0 < -rr) && (p1 < -rr)))) begin
                    n_crs = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath stages
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 0: capture word
            r_s0_vtx[0][0] <= i_tri.a_x;
            r_s0_vtx[0][1] <= i_tri.a_y;
            r_s0_vtx[0][2] <= i_tri.a_z;
            r_s0_vtx[1][0] <= i_tri.b_x;
            r_s0_vtx[1][1] <= i_tri.b_y;
            r_s0_vtx[1][2] <= i_tri.b_z;
            r_s0_vtx[2][0] <= i_tri.c_x;
            r_s0_vtx[2][1] <= i_tri.c_y;
            r_s0_vtx[2][2] <= i_tri.c_z;
            r_s0_idx[0]    <= w_wrap[i_tri.cell_x];
            r_s0_idx[1]    <= w_wrap[i_tri.cell_y];
            r_s0_idx[2]    <= w_wrap[i_tri.cell_z];

            r_s1_vtx <= r_s0_vtx;
            r_s2_vtx <= r_s1_vtx;
            r_s4_v   <= r_s3_v;
            r_s5_e   <= r_s4_e;
            r_s5_v   <= r_s4_v;
            r_s11_n  <= r_s10_n;

            for (int k = 0; k < 3; k++) begin
                // stage 1: cell offset (2*idx+1)*cs
                r_s1_off[k] <= (WOFF+1)'({r_s0_idx[k], 1'b1}) * (WOFF+1)'(w_cs);
                // stage 2: doubled cell center
                r_s2_ctr[k] <= (WC'(r_org[k]) <<< 1) + WC'(r_s1_off[k]);
                // stage 3: vertices relative to the center
                for (int i = 0; i < 3; i++) begin
                    r_s3_v[i][k] <= (WV'(r_s2_vtx[i][k]) <<< 1) - WV'(r_s2_ctr[k]);
                end
                // stage 4: edges
                r_s4_e[0][k] <= WE'(r_s3_v[1][k]) - WE'(r_s3_v[0][k]);
                r_s4_e[1][k] <= WE'(r_s3_v[2][k]) - WE'(r_s3_v[1][k]);
                r_s4_e[2][k] <= WE'(r_s3_v[0][k]) - WE'(r_s3_v[2][k]);
                // stage 5: L1 length of each cross axis
                for (int j = 0; j < 3; j++) begin
                    r_s5_asum[k][j] <= abs_e(r_s4_e[j][nx1(k)]) + abs_e(r_s4_e[j][nx2(k)]);
                end
                // stage 10: normal, projections, axis length check
                r_s10_n[k] <= WN'(w_nm1[k]) - WN'(w_nm2[k]);
                for (int j = 0; j < 3; j++) begin
                    r_s10_sqok[k][j] <= (WSQ'(w_sq[j][nx1(k)]) + WSQ'(w_sq[j][nx2(k)]))
                                        > WSQ'(AXIS_SQ_MIN);
                    r_s10_r3[k][j]   <= w_r3[k][j];
                    for (int t = 0; t < 2; t++) begin
                        r_s10_p[k][j][t] <= WP'(w_pm1[k][j][t]) - WP'(w_pm2[k][j][t]);
                    end
                end
            end

            // first vertex travels to the normal projection
            r_v0d[6] <= r_s5_v[0];
            for (int s = 7; s <= 11; s++) begin
                r_v0d[s] <= r_v0d[s-1];
            end

            // stage 11: L1 length of the normal
            r_s11_nabs <= abs_n(r_s10_n[0]) + abs_n(r_s10_n[1]) + abs_n(r_s10_n[2]);

            // stage 16: normal projection and radius
            r_s16_d <= WD'(w_dm[0]) + WD'(w_dm[1]) + WD'(w_dm[2]);
            r_s16_r <= w_r;

            // axis flags travel with the word
            r_box <= {r_box[S_LAST-1:S_BOX], n_box};
            r_crs <= {r_crs[S_LAST-1:S_CRS], n_crs};
        end
    end

    // ------------------------------------------------------------------
    // multiplier bank, round one: inputs at stage 5, outputs at stage 9
    // ------------------------------------------------------------------
    for (genvar k = 0; k < 3; k++) begin : g_k
        localparam int AX = nx1(k);
        localparam int BX = nx2(k);

        tvo_mul #(.WA(WE), .WB(WE)) u_nm1 (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(r_s5_e[0][AX]), .i_b(r_s5_e[1][BX]), .o_p(w_nm1[k])
        );
        tvo_mul #(.WA(WE), .WB(WE)) u_nm2 (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(r_s5_e[0][BX]), .i_b(r_s5_e[1][AX]), .o_p(w_nm2[k])
        );

        for (genvar j = 0; j < 3; j++) begin : g_j
            tvo_mul #(.WA(WE), .WB(WE)) u_sq (
                .i_clk(i_clk), .i_en(w_en),
                .i_a(r_s5_e[j][k]), .i_b(r_s5_e[j][k]), .o_p(w_sq[j][k])
            );
            tvo_mul #(.WA(WA3), .WB(CS_W+1)) u_r3 (
                .i_clk(i_clk), .i_en(w_en),
                .i_a(r_s5_asum[k][j]), .i_b(w_cs32), .o_p(w_r3[k][j])
            );

            // the edge's own endpoints project alike: use one of them and the third
            for (genvar t = 0; t < 2; t++) begin : g_t
                localparam int IT = (t == 0) ? j : nx2(j);

                tvo_mul #(.WA(WE), .WB(WV)) u_pm1 (
                    .i_clk(i_clk), .i_en(w_en),
                    .i_a(r_s5_e[j][AX]), .i_b(r_s5_v[IT][BX]), .o_p(w_pm1[k][j][t])
                );
                tvo_mul #(.WA(WE), .WB(WV)) u_pm2 (
                    .i_clk(i_clk), .i_en(w_en),
                    .i_a(r_s5_e[j][BX]), .i_b(r_s5_v[IT][AX]), .o_p(w_pm2[k][j][t])
                );
            end
        end

        // round two: inputs at stage 11, outputs at stage 15
        tvo_mul #(.WA(WN), .WB(WV)) u_dm (
            .i_clk(i_clk), .i_en(w_en),
            .i_a(r_s11_n[k]), .i_b(r_v0d[11][k]), .o_p(w_dm[k])
        );
    end

    tvo_mul #(.WA(WNA), .WB(CS_W+1)) u_rm (
        .i_clk(i_clk), .i_en(w_en),
        .i_a(r_s11_nabs), .i_b(w_cs32), .o_p(w_r)
    );

    // ------------------------------------------------------------------
    // classify in test order
    // ------------------------------------------------------------------
    assign w_rd  = WD'(r_s16_r);
    assign w_nrm = (r_s16_d > w_rd) || (r_s16_d < -w_rd);

    always_comb begin
        if (r_box[S_LAST]) begin
            n_res.sep = SEP_BOX;
        end else if (w_nrm) begin
            n_res.sep = SEP_NORMAL;
        end else if (r_crs[S_LAST]) begin
            n_res.sep = SEP_CROSS;
        end else begin
            n_res.sep = SEP_NONE;
        end
        n_res.overlap = (n_res.sep == SEP_NONE);
        n_res.value   = n_res.overlap ? r_material : '0;
    end

    // ------------------------------------------------------------------
    // output register with skid word
    // ------------------------------------------------------------------
    assign w_take = r_out_v && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_vld[S_LAST]) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (r_vld[S_LAST]) begin
            if (!r_out_v || w_take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.overlap      = r_out.overlap;
    assign o_res.voxel_value  = r_out.value;
    assign o_res.separated_by = r_out.sep;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `TVO_ASSERT_HOLD(a_skid_has_out, r_skid_v, r_out_v, "skid word held without output word")
    `TVO_ASSERT_HOLD(a_overlap_code, r_out_v, r_out.overlap == (r_out.sep == SEP_NONE), "overlap disagrees with axis class")
    `TVO_ASSERT_HOLD(a_miss_zero, r_out_v && !r_out.overlap, r_out.value == '0, "nonzero value for a miss")
    `TVO_ASSERT_NEXT(a_accept_enters, w_acc, r_vld[0], "accepted word missing from first stage")
    `TVO_ASSERT_HOLD(a_skid_fill, $rose(r_skid_v), $past(r_out_v && !o_res.ready), "skid filled without a stall")

endmodule

### sim/tvo_overlap_checker.sv
// ----------------------------------------------------------------------------
// tvo_overlap_checker
// Watches the triangle and result channels, predicts each overlap verdict
// with exact separating-axis arithmetic, and compares it in order.
// ----------------------------------------------------------------------------
module tvo_overlap_checker
    import tvo_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    tvo_in_if      tri_ch,
    tvo_out_if     res_ch,
    output int     o_fail_count,
    output int     o_pending
);

    typedef logic signed [255:0] t_wide;

    logic signed [31:0] org_x, org_y, org_z;
    logic [CS_W-1:0]    cell_sz;
    logic [MAT_W-1:0]   mat;
    t_res               verdict_q[$];

    // true when the three projections all lie strictly above r or all strictly below -r
    function automatic bit outside(t_wide p0, t_wide p1, t_wide p2, t_wide r);
        t_wide lo, hi;
        lo = p0; hi = p0;
        if (p1 < lo) lo = p1;
        if (p1 > hi) hi = p1;
        if (p2 < lo) lo = p2;
        if (p2 > hi) hi = p2;
        return (lo > r) || (hi < -r);
    endfunction

    function automatic t_wide wabs(t_wide x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic t_sep classify_overlap(t_wide vx[3][3]);
        t_wide cs, e[3][3], n[3], d, r, ax[3], sq, p[3];
        int a, b;
        cs = (cell_sz < CELL_MIN) ? CELL_MIN : cell_sz;
        for (int k = 0; k < 3; k++) begin
            e[0][k] = vx[1][k] - vx[0][k];
            e[1][k] = vx[2][k] - vx[1][k];
            e[2][k] = vx[0][k] - vx[2][k];
        end
        for (int k = 0; k < 3; k++)
            if (outside(vx[0][k], vx[1][k], vx[2][k], cs)) return SEP_BOX;
        for (int k = 0; k < 3; k++) begin
            a = (k + 1) % 3; b = (k + 2) % 3;
            n[k] = e[0][a] * e[1][b] - e[0][b] * e[1][a];
        end
        d = 0; r = 0;
        for (int k = 0; k < 3; k++) begin
            d += n[k] * vx[0][k];
            r += wabs(n[k]);
        end
        if (wabs(d) > r * cs) return SEP_NORMAL;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                a = (k + 1) % 3; b = (k + 2) % 3;
                ax[k] = 0; ax[a] = -e[j][b]; ax[b] = e[j][a];
                sq = ax[0] * ax[0] + ax[1] * ax[1] + ax[2] * ax[2];
                if (sq <= AXIS_SQ_MIN) continue;
                for (int i = 0; i < 3; i++)
                    p[i] = ax[0] * vx[i][0] + ax[1] * vx[i][1] + ax[2] * vx[i][2];
                r = cs * (wabs(ax[0]) + wabs(ax[1]) + wabs(ax[2]));
                if (outside(p[0], p[1], p[2], r)) return SEP_CROSS;
            end
        end
        return SEP_NONE;
    endfunction

    function automatic t_res predict_verdict();
        t_wide cs, ctr[3], vx[3][3], org[3], vin[3][3];
        t_res  res;
        t_sep  sep;
        cs = (cell_sz < CELL_MIN) ? CELL_MIN : cell_sz;
        org[0] = org_x; org[1] = org_y; org[2] = org_z;
        ctr[0] = 2 * org[0] + (2 * t_wide'(tri_ch.cell_x) + 1) * cs;
        ctr[1] = 2 * org[1] + (2 * t_wide'(tri_ch.cell_y) + 1) * cs;
        ctr[2] = 2 * org[2] + (2 * t_wide'(tri_ch.cell_z) + 1) * cs;
        vin[0][0] = tri_ch.a_x; vin[0][1] = tri_ch.a_y; vin[0][2] = tri_ch.a_z;
        vin[1][0] = tri_ch.b_x; vin[1][1] = tri_ch.b_y; vin[1][2] = tri_ch.b_z;
        vin[2][0] = tri_ch.c_x; vin[2][1] = tri_ch.c_y; vin[2][2] = tri_ch.c_z;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                vx[i][k] = 2 * vin[i][k] - ctr[k];
        sep = classify_overlap(vx);
        res.overlap = (sep == SEP_NONE);
        res.value   = (sep == SEP_NONE) ? mat : '0;
        res.sep     = sep;
        return res;
    endfunction

    // track registers, queue predictions, compare results
    always @(posedge i_clk) begin
        t_res exp_r;
        if (!i_rst_n) begin
            org_x <= 0; org_y <= 0; org_z <= 0;
            cell_sz <= CELL_SIZE_RST;
            mat <= MATERIAL_RST;
            o_fail_count <= 0;
            o_pending <= 0;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ORIGIN_X:  org_x <= i_cfg_data;
                    REG_ORIGIN_Y:  org_y <= i_cfg_data;
                    REG_ORIGIN_Z:  org_z <= i_cfg_data;
                    REG_CELL_SIZE: cell_sz <= i_cfg_data[CS_W-1:0];
                    REG_MATERIAL:  mat <= i_cfg_data[MAT_W-1:0];
                    default: ;
                endcase
            end
            if (tri_ch.valid && tri_ch.ready) begin
                verdict_q.insert(verdict_q.size(), predict_verdict());
            end
            if (res_ch.valid && res_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result word ov=%0b val=%0d sep=%0d", $time,
                             res_ch.overlap, res_ch.voxel_value, res_ch.separated_by);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = verdict_q.pop_front();
                    if (exp_r.overlap !== res_ch.overlap ||
                        exp_r.value !== res_ch.voxel_value ||
                        exp_r.sep !== res_ch.separated_by) begin
                        $display("%0t: mismatch expected ov=%0b val=%0d sep=%0d, actual ov=%0b val=%0d sep=%0d",
                                 $time, exp_r.overlap, exp_r.value, exp_r.sep,
                                 res_ch.overlap, res_ch.voxel_value, res_ch.separated_by);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= verdict_q.size();
        end
    end

endmodule

### sim/tb_triangle_voxel_overlap_test_top.sv
// ----------------------------------------------------------------------------
// tb_triangle_voxel_overlap_test_top
// Drives triangles and cell indexes through several grid settings, with
// random idling on both channels; the checker predicts every verdict.
// ----------------------------------------------------------------------------
module tb_triangle_voxel_overlap_test_top;
    import tvo_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic i_clk, i_rst_n, i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;
    int   fail_count, pending;
    int   cycles = 0;
    bit   calm;

    tvo_in_if  tri_ch ();
    tvo_out_if res_ch ();

    triangle_voxel_overlap_test_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_tri(tri_ch), .o_res(res_ch)
    );

    tvo_overlap_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .tri_ch(tri_ch), .res_ch(res_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // random receiver stalls in bursts
    initial begin
        int n;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                res_ch.ready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    // present one word and hold until accepted, with an optional leading gap
    task automatic send_triangle(logic [31:0] v[9], logic [6:0] cx, cy, cz);
        if (!calm && $urandom_range(0, 5) == 0) begin
            tri_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        tri_ch.valid <= 1'b1;
        tri_ch.a_x <= v[0]; tri_ch.a_y <= v[1]; tri_ch.a_z <= v[2];
        tri_ch.b_x <= v[3]; tri_ch.b_y <= v[4]; tri_ch.b_z <= v[5];
        tri_ch.c_x <= v[6]; tri_ch.c_y <= v[7]; tri_ch.c_z <= v[8];
        tri_ch.cell_x <= cx; tri_ch.cell_y <= cy; tri_ch.cell_z <= cz;
        @(posedge i_clk);
        while (!tri_ch.ready) @(posedge i_clk);
    endtask

    // triangle near the chosen cell: center plus random offsets of a few cells
    task automatic send_near_cell(int spread, logic [31:0] org[3], logic [30:0] cs);
        logic [31:0] v[9];
        logic [6:0]  c[3];
        longint base, off;
        for (int k = 0; k < 3; k++) c[k] = $urandom_range(0, 127);
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) begin
                base = longint'($signed(org[k])) + (longint'(c[k]) * cs) + cs / 2;
                off  = (longint'($urandom_range(0, 2 * spread)) - spread) * cs / 4
                       + longint'($urandom_range(0, 255)) - 128;
                v[i * 3 + k] = base + off;
            end
        send_triangle(v, c[0], c[1], c[2]);
    endtask

    task automatic send_random_triangle();
        logic [31:0] v[9];
        for (int i = 0; i < 9; i++) v[i] = $urandom;
        send_triangle(v, $urandom, $urandom, $urandom);
    endtask

    initial begin
        logic [31:0] v[9];
        logic [31:0] org[3];
        logic [30:0] cs;
        int sel;
        calm = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        tri_ch.valid = 0;
        {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y, tri_ch.b_z,
         tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = '0;
        {tri_ch.cell_x, tri_ch.cell_y, tri_ch.cell_z} = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default grid, unit cells
        foreach (v[i]) v[i] = 32'h0000_8000;
        send_triangle(v, 0, 0, 0);                        // degenerate point inside
        foreach (v[i]) v[i] = 32'h8000_0000;
        send_triangle(v, 127, 127, 127);                  // most negative corner
        foreach (v[i]) v[i] = 32'h7FFF_FFFF;
        send_triangle(v, 127, 0, 127);
        v = '{32'h0, 32'h0, 32'h8000, 32'h10000, 32'h0, 32'h8000, 32'h0, 32'h10000, 32'h8000};
        send_triangle(v, 0, 0, 0);                        // flat triangle through cell
        v = '{32'h0, 32'h0, 32'h30000, 32'h10000, 32'h0, 32'h30000, 32'h0, 32'h10000, 32'h30000};
        send_triangle(v, 0, 0, 0);                        // above the cell
        v = '{32'hFFFF0000, 32'h0, 32'h18000, 32'h0, 32'hFFFF0000, 32'h18000,
              32'h30000, 32'h30000, 32'hFFFE8000};
        send_triangle(v, 0, 0, 0);                        // tilted plane past the corner
        v = '{32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h2, 32'h0, 32'h0};
        send_triangle(v, 0, 0, 0);                        // short collinear edges
        v = '{32'h20000, 32'h8000, 32'h0, 32'h8000, 32'h20000, 32'h0,
              32'h20000, 32'h20000, 32'h20000};
        send_triangle(v, 0, 0, 0);                        // edge-cross candidate
        v = '{32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h10000, 32'h10000,
              32'h10000, 32'h20000, 32'h10000};
        send_triangle(v, 0, 0, 0);                        // touches closed corner
        for (int i = 0; i < 8; i++) send_random_triangle();
        tri_ch.valid <= 1'b0;
        drain_results();

        // phases through grid settings, tiny and huge cells among them
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin org = '{0, 0, 0}; cs = 31'd65536; end
                1: begin org = '{32'hFFF0_0000, 32'h0010_0000, 32'hFFFF_8000}; cs = 31'd3; end
                2: begin org = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; cs = 31'h7FFF_FFFF; end
                3: begin org = '{32'h7FFF_FFFF, 32'h0, 32'h8000_0000}; cs = 31'd7; end
                4: begin org = '{$urandom, $urandom, $urandom}; cs = $urandom_range(7, 1 << 20); end
                5: begin org = '{32'hFFC0_0000, 32'hFFC0_0000, 32'hFFC0_0000}; cs = 31'h0001_8000; end
                default: begin org = '{0, 0, 0}; cs = 31'd0; end
            endcase
            write_reg(REG_ORIGIN_X, org[0]);
            write_reg(REG_ORIGIN_Y, org[1]);
            write_reg(REG_ORIGIN_Z, org[2]);
            write_reg(REG_CELL_SIZE, {1'b0, cs});
            write_reg(REG_MATERIAL, (ph == 0) ? 32'd255 : (ph == 3) ? 32'd0 : $urandom);
            if (cs < CELL_MIN) cs = CELL_MIN;
            if (ph == 6) calm = 1;
            for (int n = 0; n < 245; n++) begin
                sel = $urandom_range(0, 9);
                if (sel < 7) send_near_cell((sel < 4) ? 4 : 12, org, cs);
                else send_random_triangle();
            end
            tri_ch.valid <= 1'b0;
            drain_results();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/tvo_pkg.sv
sv/tvo_in_if.sv
sv/tvo_out_if.sv
sv/tvo_mul.sv
sv/triangle_voxel_overlap_test_top.sv
sim/tvo_overlap_checker.sv
sim/tb_triangle_voxel_overlap_test_top.sv
